>>> design/qws_pkg.sv
// Shared types and constants for the quoted word splitter.
// Depends on nothing; used by every module of the block and by the checker.
`timescale 1ns / 1ps
`default_nettype none

package qws_pkg;

  localparam int TAB_STOP = 8;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  localparam int MAX_RES  = 3;

  localparam logic [15:0] INDENT_MAX = 16'hFFFF;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic ERR_UNTERM    = 1'b0;
  localparam logic ERR_BACKSLASH = 1'b1;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_WEND = 2'd1,
    KIND_LOK  = 2'd2,
    KIND_LERR = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       has_byte;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  word_byte;
    logic [15:0] indent_columns;
    logic        error_code;
    logic        last;
  } out_item_t;

  // one result without its last flag
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  word_byte;
    logic [15:0] indent_columns;
    logic        error_code;
  } res_t;

  // all results of one input item, in order; count is 1..3
  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [1:0]         count;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic is_sep(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_VT) ||
           (b == CH_FF) || (b == CH_CR);
  endfunction

endpackage

`default_nettype wire

>>> design/qws_front.sv
// Front end: accepts input items, runs the tokenizer phase machine and
// builds the result bundle of each item. Depends on qws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qws_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  qws_pkg::in_item_t   in_data,
  input  wire                 cfg_we,
  input  wire                 cfg_wdata,
  input  qws_pkg::q_status_t  q_stat,
  output logic                push,
  output qws_pkg::bundle_t    push_data
);

  typedef enum logic [2:0] {
    PH_INDENT  = 3'd0,
    PH_GAP     = 3'd1,
    PH_BARE    = 3'd2,
    PH_QUOTED  = 3'd3,
    PH_ESCAPE  = 3'd4,
    PH_COMMENT = 3'd5,
    PH_ERROR   = 3'd6
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] indent_count, indent_count_next;
  logic        error_seen, error_seen_next;
  logic        error_kind, error_kind_next;
  logic        measure_indent;

  logic        accept;
  logic [7:0]  b;
  logic [17:0] tab_stop_pos;
  logic        do_gap;
  logic        bres_valid;
  qws_pkg::kind_t bres_kind;
  logic        eol_wend;
  logic        line_err;
  logic        line_code;
  logic [15:0] line_indent;
  logic [1:0]  n;
  qws_pkg::bundle_t bundle;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.byte_value;

  assign tab_stop_pos = (18'(indent_count) / 18'(qws_pkg::TAB_STOP) + 18'd1) *
                        18'(qws_pkg::TAB_STOP);

  always_comb begin
    phase_next        = phase;
    indent_count_next = indent_count;
    error_seen_next   = error_seen;
    error_kind_next   = error_kind;
    do_gap            = 1'b0;
    bres_valid        = 1'b0;
    bres_kind         = qws_pkg::KIND_BYTE;
    eol_wend          = 1'b0;
    line_err          = 1'b0;
    line_code         = 1'b0;
    line_indent       = '0;

    if (in_data.has_byte) begin
      unique case (phase)
        PH_INDENT: begin
          if (b == qws_pkg::CH_SPACE) begin
            if (indent_count != qws_pkg::INDENT_MAX) begin
              indent_count_next = indent_count + 16'd1;
            end
          end else if (b == qws_pkg::CH_TAB) begin
            indent_count_next = (tab_stop_pos > 18'(qws_pkg::INDENT_MAX)) ?
                                qws_pkg::INDENT_MAX : tab_stop_pos[15:0];
          end else begin
            do_gap = 1'b1;
          end
        end
        PH_GAP: do_gap = 1'b1;
        PH_BARE: begin
          bres_valid = 1'b1;
          if (qws_pkg::is_sep(b)) begin
            bres_kind  = qws_pkg::KIND_WEND;
            phase_next = PH_GAP;
          end else if (b == qws_pkg::CH_QUOTE) begin
            bres_kind  = qws_pkg::KIND_WEND;
            phase_next = PH_QUOTED;
          end else if (b == qws_pkg::CH_BSLASH) begin
            bres_kind       = qws_pkg::KIND_WEND;
            phase_next      = PH_ERROR;
            error_seen_next = 1'b1;
            error_kind_next = qws_pkg::ERR_BACKSLASH;
          end
        end
        PH_QUOTED: begin
          if (b == qws_pkg::CH_QUOTE) begin
            bres_valid = 1'b1;
            bres_kind  = qws_pkg::KIND_WEND;
            phase_next = PH_GAP;
          end else if (b == qws_pkg::CH_BSLASH) begin
            phase_next = PH_ESCAPE;
          end else begin
            bres_valid = 1'b1;
          end
        end
        PH_ESCAPE: begin
          bres_valid = 1'b1;
          phase_next = PH_QUOTED;
        end
        PH_COMMENT, PH_ERROR: ;
        default: do_gap = 1'b1;
      endcase

      // start of a word, a comment or an error, or more gap
      if (do_gap) begin
        priority if (qws_pkg::is_sep(b)) begin
          phase_next = PH_GAP;
        end else if (b == qws_pkg::CH_HASH) begin
          phase_next = PH_COMMENT;
        end else if (b == qws_pkg::CH_QUOTE) begin
          phase_next = PH_QUOTED;
        end else if (b == qws_pkg::CH_BSLASH) begin
          phase_next      = PH_ERROR;
          error_seen_next = 1'b1;
          error_kind_next = qws_pkg::ERR_BACKSLASH;
        end else begin
          bres_valid = 1'b1;
          phase_next = PH_BARE;
        end
      end
    end

    if (in_data.end_of_line) begin
      line_err    = error_seen_next;
      line_code   = error_kind_next;
      line_indent = measure_indent ? indent_count_next : '0;
      if (phase_next == PH_BARE) begin
        eol_wend = 1'b1;
      end else if (phase_next == PH_QUOTED || phase_next == PH_ESCAPE) begin
        line_err  = 1'b1;
        line_code = qws_pkg::ERR_UNTERM;
      end
      phase_next        = PH_INDENT;
      indent_count_next = '0;
      error_seen_next   = 1'b0;
      error_kind_next   = 1'b0;
    end
  end

  // pack the results in order: byte part, then word end, then line end
  always_comb begin
    bundle = '0;
    n      = 2'd0;
    if (bres_valid) begin
      bundle.res[n].kind      = bres_kind;
      bundle.res[n].word_byte = (bres_kind == qws_pkg::KIND_BYTE) ? b : 8'd0;
      n = n + 2'd1;
    end
    if (in_data.end_of_line) begin
      if (eol_wend) begin
        bundle.res[n].kind = qws_pkg::KIND_WEND;
        n = n + 2'd1;
      end
      bundle.res[n].kind           = line_err ? qws_pkg::KIND_LERR : qws_pkg::KIND_LOK;
      bundle.res[n].indent_columns = line_indent;
      bundle.res[n].error_code     = line_err ? line_code : 1'b0;
      n = n + 2'd1;
    end
    bundle.count = n;
  end

  assign push      = accept && (n != 2'd0);
  assign push_data = bundle;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_INDENT;
      indent_count   <= '0;
      error_seen     <= 1'b0;
      error_kind     <= 1'b0;
      measure_indent <= 1'b1;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        indent_count <= indent_count_next;
        error_seen   <= error_seen_next;
        error_kind   <= error_kind_next;
      end
      if (cfg_we) begin
        measure_indent <= cfg_wdata;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/qws_queue.sv
// Short bundle queue between the front end and the result sequencer.
// Depends on qws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qws_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  qws_pkg::bundle_t    push_data,
  input  wire                 pop,
  output qws_pkg::bundle_t    head,
  output qws_pkg::q_status_t  q_stat
);

  qws_pkg::bundle_t entries [qws_pkg::QDEPTH];
  logic [qws_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [qws_pkg::QCNT_W-1:0] count;
  logic do_push, do_pop;

  assign q_stat.full  = (count == qws_pkg::QCNT_W'(qws_pkg::QDEPTH));
  assign q_stat.empty = (count == '0);
  assign head         = entries[rd_ptr];

  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == qws_pkg::QPTR_W'(qws_pkg::QDEPTH - 1)) ? '0 :
                  wr_ptr + qws_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == qws_pkg::QPTR_W'(qws_pkg::QDEPTH - 1)) ? '0 :
                  rd_ptr + qws_pkg::QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + qws_pkg::QCNT_W'(1);
        2'b01:   count <= count - qws_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/qws_back.sv
// Back end: walks the results of the head bundle one per cycle into the
// output register while the output is not stalled. Depends on qws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qws_back (
  input  wire                 clk,
  input  wire                 rst,
  input  qws_pkg::bundle_t    head,
  input  qws_pkg::q_status_t  q_stat,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output qws_pkg::out_item_t  out_data
);

  logic [1:0]  sub;
  logic        load;
  logic        is_last;
  qws_pkg::res_t cur;

  assign cur     = head.res[sub];
  assign is_last = (sub == head.count - 2'd1);
  assign load    = !q_stat.empty && (!out_valid || out_ready);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.kind           <= cur.kind;
      out_data.word_byte      <= cur.word_byte;
      out_data.indent_columns <= cur.indent_columns;
      out_data.error_code     <= cur.error_code;
      out_data.last           <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sub       <= is_last ? 2'd0 : sub + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/quoted_word_splitter.sv
// Quoted word splitter: one byte per item in, word bytes / word ends / line ends out.
// The results of an item pass through the bundle queue and then the output register.
// Throughput: one input transfer per cycle while each item yields at most one
// result and the output is not stalled; results leave at one per cycle, so the output port bounds the rate.
// Reset (rst, synchronous): line-start state, empty queue, measure_indent = 1.
// Top level; depends on qws_pkg, qws_front, qws_queue and qws_back.
`timescale 1ns / 1ps
`default_nettype none

module quoted_word_splitter (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  qws_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output qws_pkg::out_item_t  out_data,
  input  wire                 cfg_we,
  input  wire                 cfg_wdata
);

  logic               push, pop;
  qws_pkg::bundle_t   push_data, head;
  qws_pkg::q_status_t q_stat;

  qws_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  qws_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  qws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> design/qws_checker.sv
// Port-level checker for quoted_word_splitter, attached by bind.
// Depends on qws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qws_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 out_valid,
  input wire                 out_ready,
  input qws_pkg::out_item_t  out_data
);

  // a held result stays put until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // a line end always closes the results of its item
  a_line_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == qws_pkg::KIND_LOK ||
                  out_data.kind == qws_pkg::KIND_LERR) |-> out_data.last)
    else $error("line end without last");

  a_byte_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != qws_pkg::KIND_BYTE |-> out_data.word_byte == 8'd0)
    else $error("word byte set on a non-byte result");

  a_indent_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == qws_pkg::KIND_BYTE ||
                  out_data.kind == qws_pkg::KIND_WEND) |->
      out_data.indent_columns == 16'd0 && out_data.error_code == 1'b0)
    else $error("indent or error code set on a word result");

endmodule

bind quoted_word_splitter qws_checker u_qws_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
